// ----- hw/rtl/tlpl_pkg.sv -----
package tlpl_pkg;

    localparam int PAGE_BYTES    = 256;
    localparam int VIRTUAL_PAGES = 16;
    localparam int FRAME_COUNT   = 8;
    localparam int TLB_ENTRIES   = 4;

    localparam int VA_W     = 12;
    localparam int OFFSET_W = $clog2(PAGE_BYTES);
    localparam int PAGE_W   = $clog2(VIRTUAL_PAGES);
    localparam int FRAME_W  = $clog2(FRAME_COUNT);
    localparam int PA_W     = FRAME_W + OFFSET_W;
    localparam int SLOT_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int COUNT_W  = $clog2(FRAME_COUNT + 1);

    // Changes applied to the TLB when an item completes.
    typedef struct packed {
        logic               load;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic               inval;
        logic [PAGE_W-1:0]  inval_page;
    } tlb_upd_t;

    // Lookup result of the TLB for the item in flight.
    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [FRAME_W-1:0] frame;
        logic [SLOT_W-1:0]  fill_slot;
    } tlb_look_t;

endpackage

// ----- hw/rtl/tlpl_tlb.sv -----
module tlpl_tlb
    import tlpl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [PAGE_W-1:0] lookup_page,
    input  tlb_upd_t          upd,
    output tlb_look_t         look
);

    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [TLB_ENTRIES-1:0] valid_next;
    logic [PAGE_W-1:0]      page_reg  [TLB_ENTRIES];
    logic [FRAME_W-1:0]     frame_reg [TLB_ENTRIES];
    logic [SLOT_W-1:0]      fill_reg;
    logic [SLOT_W-1:0]      fill_next;

    // Fully associative search; the lowest matching entry wins.
    always_comb begin
        look           = '0;
        look.fill_slot = fill_reg;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i] && page_reg[i] == lookup_page) begin
                look.hit   = 1'b1;
                look.slot  = SLOT_W'(i);
                look.frame = frame_reg[i];
            end
        end
    end

    // The invalidation of an evicted page comes first, so a load into the
    // same entry leaves it valid.
    always_comb begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            valid_next[i] = valid_reg[i];
            if (upd.inval && page_reg[i] == upd.inval_page) begin
                valid_next[i] = 1'b0;
            end
            if (upd.load && fill_reg == SLOT_W'(i)) begin
                valid_next[i] = 1'b1;
            end
        end
        fill_next = fill_reg;
        if (upd.load) begin
            fill_next = (fill_reg == SLOT_W'(TLB_ENTRIES - 1)) ? '0 : fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fill_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.load) begin
            page_reg[fill_reg]  <= upd.page;
            frame_reg[fill_reg] <= upd.frame;
        end
    end

endmodule

// ----- hw/rtl/tlpl_lru.sv -----
module tlpl_lru
    import tlpl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               touch_en,
    input  logic [FRAME_W-1:0] touch_frame,
    output logic [COUNT_W-1:0] count,
    output logic [FRAME_W-1:0] oldest
);

    // Recency order of the occupied frames, least recently used at entry 0.
    // Frames and resident pages map one to one, so frames stand for pages.
    logic [FRAME_W-1:0] list_reg  [FRAME_COUNT];
    logic [FRAME_W-1:0] list_next [FRAME_COUNT];
    logic [FRAME_W-1:0] upper     [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] shift;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               found;

    for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_upper
        if (g < FRAME_COUNT - 1) begin : g_mid
            assign upper[g] = list_reg[g + 1];
        end else begin : g_last
            assign upper[g] = '0;
        end
    end

    // Every entry at or above the match moves down one place.
    always_comb begin
        found = 1'b0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (COUNT_W'(i) < count_reg && list_reg[i] == touch_frame) begin
                found = 1'b1;
            end
            shift[i] = found;
        end
    end

    always_comb begin
        for (int i = 0; i < FRAME_COUNT; i++) begin
            list_next[i] = list_reg[i];
            if (found) begin
                if (COUNT_W'(i + 1) == count_reg) begin
                    list_next[i] = touch_frame;
                end else if (shift[i] && COUNT_W'(i + 1) < count_reg) begin
                    list_next[i] = upper[i];
                end
            end else if (COUNT_W'(i) == count_reg) begin
                list_next[i] = touch_frame;
            end
        end
        count_next = count_reg;
        if (!found && count_reg < COUNT_W'(FRAME_COUNT)) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (touch_en) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (touch_en) begin
            list_reg <= list_next;
        end
    end

    assign count  = count_reg;
    assign oldest = list_reg[0];

endmodule

// ----- hw/rtl/tlb_paging_lru_translator.sv -----
// Address translator: a small FIFO-refilled TLB in front of a demand-paged
// page table with least-recently-used eviction.
// Input channel (s_valid/s_ready): one virtual address per item.
// Result channel (m_valid/m_ready): one result per item with the TLB hit and
// page fault flags, the frame, the physical address, the TLB entry used and
// the page evicted, if any.
// An accepted item waits in the input register while the lookup and update
// logic works on it, and enters the result register once that register is
// empty or being drained, so its result is registered. One item is
// taken per cycle as long as results are drained; the tables are read and
// updated in the same cycle, so each item sees the state its predecessor left.
// When the receiver stalls, the result register holds and the input register
// fills; s_ready drops once both are occupied, and rises again in the cycle
// m_ready returns.
// Reset (aresetn low, synchronous) empties the TLB, the page table and the
// recency list and drops both pipeline registers. The block is ready as
// soon as reset is released.
module tlb_paging_lru_translator
    import tlpl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VA_W-1:0]    s_virtual_address,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_tlb_hit,
    output logic               m_page_fault,
    output logic [FRAME_W-1:0] m_frame_number,
    output logic [PA_W-1:0]    m_physical_address,
    output logic [SLOT_W-1:0]  m_tlb_slot,
    output logic               m_evicted_valid,
    output logic [PAGE_W-1:0]  m_evicted_page
);

    logic                     in_valid_reg;
    logic [VA_W-1:0]          va_reg;
    logic                     out_valid_reg;
    logic                     hit_reg;
    logic                     fault_reg;
    logic [FRAME_W-1:0]       frame_reg;
    logic [PA_W-1:0]          pa_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic                     ev_valid_reg;
    logic [PAGE_W-1:0]        ev_page_reg;

    logic [VIRTUAL_PAGES-1:0] resident_reg;
    logic [VIRTUAL_PAGES-1:0] resident_next;
    logic [FRAME_W-1:0]       page_frame_reg [VIRTUAL_PAGES];
    logic [PAGE_W-1:0]        frame_page_reg [FRAME_COUNT];

    logic                     advance;
    logic [PAGE_W-1:0]        page;
    logic [OFFSET_W-1:0]      offset;
    tlb_look_t                look;
    tlb_upd_t                 upd;
    logic [COUNT_W-1:0]       lru_count;
    logic [FRAME_W-1:0]       lru_oldest;
    logic                     resident;
    logic                     fault;
    logic                     evict;
    logic [PAGE_W-1:0]        victim_page;
    logic [FRAME_W-1:0]       frame;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign page   = va_reg[OFFSET_W +: PAGE_W];
    assign offset = va_reg[OFFSET_W-1:0];

    tlpl_tlb u_tlb (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lookup_page (page),
        .upd         (upd),
        .look        (look)
    );

    tlpl_lru u_lru (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .touch_en    (advance),
        .touch_frame (frame),
        .count       (lru_count),
        .oldest      (lru_oldest)
    );

    // Frames are taken first-fit and never released, so the occupied frames
    // are always the lowest ones and the next free frame equals the count.
    always_comb begin
        resident    = resident_reg[page];
        fault       = !look.hit && !resident;
        evict       = fault && (lru_count == COUNT_W'(FRAME_COUNT));
        victim_page = frame_page_reg[lru_oldest];
        if (look.hit) begin
            frame = look.frame;
        end else if (resident) begin
            frame = page_frame_reg[page];
        end else if (evict) begin
            frame = lru_oldest;
        end else begin
            frame = lru_count[FRAME_W-1:0];
        end

        upd.load       = advance && !look.hit;
        upd.page       = page;
        upd.frame      = frame;
        upd.inval      = advance && evict;
        upd.inval_page = victim_page;

        resident_next = resident_reg;
        if (evict) begin
            resident_next[victim_page] = 1'b0;
        end
        if (fault) begin
            resident_next[page] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            resident_reg  <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                resident_reg  <= resident_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            va_reg <= s_virtual_address;
        end
        if (advance) begin
            hit_reg      <= look.hit;
            fault_reg    <= fault;
            frame_reg    <= frame;
            pa_reg       <= {frame, offset};
            slot_reg     <= look.hit ? look.slot : look.fill_slot;
            ev_valid_reg <= evict;
            ev_page_reg  <= evict ? victim_page : '0;
            if (fault) begin
                page_frame_reg[page]  <= frame;
                frame_page_reg[frame] <= page;
            end
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_tlb_hit          = hit_reg;
    assign m_page_fault       = fault_reg;
    assign m_frame_number     = frame_reg;
    assign m_physical_address = pa_reg;
    assign m_tlb_slot         = slot_reg;
    assign m_evicted_valid    = ev_valid_reg;
    assign m_evicted_page     = ev_page_reg;

    a_evict_needs_fault : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted_valid |-> m_page_fault && !m_tlb_hit)
        else $error("eviction reported without a page fault");

    a_count_bounded : assert property (@(posedge aclk) disable iff (!aresetn)
        lru_count <= COUNT_W'(FRAME_COUNT))
        else $error("recency count exceeds the frame count");

    a_evict_keeps_full : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && evict |=> lru_count == COUNT_W'(FRAME_COUNT))
        else $error("frame table not full after an eviction");

    a_fault_grows : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && fault && !evict |=> lru_count == $past(lru_count) + 1'b1)
        else $error("fault into a free frame did not grow the recency list");

endmodule
